// ===== rtl/srd_pkg.sv =====
// srd_pkg: types, codes and helpers shared by the scan reply decoder.
// No dependencies; used by srd_echo, srd_parse and scan_reply_decoder.
`timescale 1ns / 1ps

package srd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RANGE_W  = 18;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned LEN_W    = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned STEP_W   = 10;
    localparam int unsigned SKIP_W   = 7;

    localparam logic [BYTE_W-1:0]  C_NEWLINE   = 8'h0A;
    localparam logic [5:0]         C_CHAR_BIAS = 6'h30;
    localparam logic [POS_W-1:0]   C_POS_MAX   = 7'd127;
    localparam logic [LEN_W-1:0]   C_LEN_STATUS     = 4'd3;
    localparam logic [LEN_W-1:0]   C_LEN_ECHO_SHORT = 4'd12;
    localparam logic [LEN_W-1:0]   C_LEN_ECHO_LONG  = 4'd13;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_RANGE      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ECHO_BAD   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STATUS_BAD = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT = 2'd2;

    // Reset values, already in BCD (thousands..ones)
    localparam logic [15:0] C_START_BCD_RST = 16'h0000;
    localparam logic [15:0] C_END_BCD_RST   = 16'h0768;
    localparam logic [11:0] C_SKIP_BCD_RST  = 12'h001;

    typedef enum logic [3:0] {
        PH_ECHO   = 4'b0001,
        PH_STATUS = 4'b0010,
        PH_STAMP  = 4'b0100,
        PH_DATA   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;   // expected echo character at line_pos
        logic [LEN_W-1:0]  len;  // echo line length without newline
    } t_echo_ref;

    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [RANGE_W-1:0] value;
    } t_result;

    // Four BCD digits of a value below 1024. Hundreds and tens come from
    // reciprocal multiplies (x*41>>12 for x<1000, x*205>>11 for x<100).
    function automatic logic [15:0] to_bcd4(input logic [9:0] v);
        logic        th;
        logic [9:0]  r;
        logic [15:0] ph;
        logic [3:0]  h;
        logic [6:0]  r2;
        logic [14:0] pt;
        logic [3:0]  t;
        logic [3:0]  o;
        th = (v >= 10'd1000);
        r  = th ? (v - 10'd1000) : v;
        ph = {6'd0, r} * 16'd41;
        h  = ph[15:12];
        r2 = 7'(r - {6'd0, h} * 10'd100);
        pt = {8'd0, r2} * 15'd205;
        t  = pt[14:11];
        o  = 4'(r2 - {3'd0, t} * 7'd10);
        return {3'd0, th, h, t, o};
    endfunction

endpackage

// ===== rtl/srd_echo.sv =====
// srd_echo: holds the scan request settings as BCD digits and supplies the
// expected echo character for a line position. Depends on srd_pkg.
`timescale 1ns / 1ps

module srd_echo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [srd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [srd_pkg::POS_W-1:0]       i_line_pos,
    output srd_pkg::t_echo_ref              o_echo
);
    import srd_pkg::*;

    logic [15:0] r_start_bcd;
    logic [15:0] r_end_bcd;
    logic [11:0] r_skip_bcd;   // hundreds, tens, ones
    logic [15:0] w_skip_full;

    assign w_skip_full = to_bcd4({3'd0, i_cfg_data[SKIP_W-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_bcd <= C_START_BCD_RST;
            r_end_bcd   <= C_END_BCD_RST;
            r_skip_bcd  <= C_SKIP_BCD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_STEP: r_start_bcd <= to_bcd4(i_cfg_data[STEP_W-1:0]);
                CFG_END_STEP:   r_end_bcd   <= to_bcd4(i_cfg_data[STEP_W-1:0]);
                CFG_SKIP_COUNT: r_skip_bcd  <= w_skip_full[11:0];
                default: ;
            endcase
        end
    end

    logic       w_skip_wide;
    logic [3:0] w_digit;
    logic       w_is_digit;

    assign w_skip_wide = (r_skip_bcd[11:8] != 4'd0);

    always_comb begin
        w_digit    = 4'd0;
        w_is_digit = 1'b1;
        o_echo.ch  = 8'h00;
        case (i_line_pos)
            7'd0:  begin w_is_digit = 1'b0; o_echo.ch = 8'h47; end  // 'G'
            7'd1:  begin w_is_digit = 1'b0; o_echo.ch = 8'h44; end  // 'D'
            7'd2:  w_digit = r_start_bcd[15:12];
            7'd3:  w_digit = r_start_bcd[11:8];
            7'd4:  w_digit = r_start_bcd[7:4];
            7'd5:  w_digit = r_start_bcd[3:0];
            7'd6:  w_digit = r_end_bcd[15:12];
            7'd7:  w_digit = r_end_bcd[11:8];
            7'd8:  w_digit = r_end_bcd[7:4];
            7'd9:  w_digit = r_end_bcd[3:0];
            7'd10: w_digit = w_skip_wide ? r_skip_bcd[11:8] : r_skip_bcd[7:4];
            7'd11: w_digit = w_skip_wide ? r_skip_bcd[7:4]  : r_skip_bcd[3:0];
            7'd12: w_digit = r_skip_bcd[3:0];
            default: w_is_digit = 1'b0;
        endcase
        if (w_is_digit) begin
            o_echo.ch = {4'h3, w_digit};
        end
        o_echo.len = w_skip_wide ? C_LEN_ECHO_LONG : C_LEN_ECHO_SHORT;
    end

endmodule

// ===== rtl/srd_parse.sv =====
// srd_parse: line parser state and per-byte decode of the scan reply.
// Depends on srd_pkg; the expected echo character comes from srd_echo.
`timescale 1ns / 1ps

module srd_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [srd_pkg::BYTE_W-1:0]  i_byte,
    input  srd_pkg::t_echo_ref          i_echo,
    output logic [srd_pkg::POS_W-1:0]   o_line_pos,
    output srd_pkg::t_result            o_result
);
    import srd_pkg::*;

    t_phase             r_phase,      n_phase;
    logic [POS_W-1:0]   r_line_pos,   n_line_pos;
    logic               r_line_bad,   n_line_bad;
    logic [BYTE_W-1:0]  r_held_char,  n_held_char;
    logic               r_held_valid, n_held_valid;
    logic [1:0]         r_group_pos,  n_group_pos;
    logic [11:0]        r_group_acc,  n_group_acc;

    logic               w_newline;
    logic [POS_W-1:0]   w_pos_inc;
    logic [BYTE_W-1:0]  w_expect;
    logic [LEN_W-1:0]   w_len;
    logic [5:0]         w_six;

    assign o_line_pos = r_line_pos;
    assign w_newline  = (i_byte == C_NEWLINE);
    assign w_pos_inc  = (r_line_pos < C_POS_MAX) ? r_line_pos + 7'd1 : r_line_pos;
    assign w_six      = r_held_char[5:0] - C_CHAR_BIAS;

    // Status line is "00P"
    always_comb begin
        if (r_phase == PH_ECHO) begin
            w_expect = i_echo.ch;
            w_len    = i_echo.len;
        end else begin
            w_expect = (r_line_pos == 7'd2) ? 8'h50 : 8'h30;
            w_len    = C_LEN_STATUS;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_line_pos   = r_line_pos;
        n_line_bad   = r_line_bad;
        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        n_group_pos  = r_group_pos;
        n_group_acc  = r_group_acc;
        o_result     = '0;

        case (r_phase)
            PH_ECHO, PH_STATUS: begin
                if (w_newline) begin
                    n_line_pos = '0;
                    n_line_bad = 1'b0;
                    if (!r_line_bad && (r_line_pos == {3'd0, w_len})) begin
                        n_phase = (r_phase == PH_ECHO) ? PH_STATUS : PH_STAMP;
                    end else begin
                        o_result.valid = 1'b1;
                        o_result.kind  = (r_phase == PH_ECHO) ? KIND_ECHO_BAD
                                                              : KIND_STATUS_BAD;
                        n_phase = PH_ECHO;
                    end
                end else begin
                    if ((r_line_pos >= {3'd0, w_len}) || (w_expect != i_byte)) begin
                        n_line_bad = 1'b1;
                    end
                    n_line_pos = w_pos_inc;
                end
            end
            PH_STAMP: begin
                if (w_newline) begin
                    n_phase      = PH_DATA;
                    n_line_pos   = '0;
                    n_line_bad   = 1'b0;
                    n_held_char  = '0;
                    n_held_valid = 1'b0;
                    n_group_pos  = '0;
                    n_group_acc  = '0;
                end
            end
            PH_DATA: begin
                if (w_newline) begin
                    // held byte was the checksum
                    n_held_valid = 1'b0;
                    n_held_char  = '0;
                    n_line_pos   = '0;
                    if (r_line_pos == '0) begin
                        // empty line: scan done, partial group dropped
                        n_phase        = PH_ECHO;
                        n_line_bad     = 1'b0;
                        n_group_pos    = '0;
                        n_group_acc    = '0;
                        o_result.valid = 1'b1;
                        o_result.kind  = KIND_DONE;
                    end
                end else begin
                    n_line_pos   = w_pos_inc;
                    n_held_char  = i_byte;
                    n_held_valid = 1'b1;
                    if (r_held_valid) begin
                        if (r_group_pos == 2'd2) begin
                            o_result.valid = 1'b1;
                            o_result.kind  = KIND_RANGE;
                            o_result.value = {r_group_acc, w_six};
                            n_group_pos    = '0;
                            n_group_acc    = '0;
                        end else begin
                            n_group_acc = {r_group_acc[5:0], w_six};
                            n_group_pos = r_group_pos + 2'd1;
                        end
                    end
                end
            end
            default: n_phase = PH_ECHO;
        endcase

        if (!i_step) begin
            o_result.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_ECHO;
            r_line_pos   <= '0;
            r_line_bad   <= 1'b0;
            r_held_char  <= '0;
            r_held_valid <= 1'b0;
            r_group_pos  <= '0;
            r_group_acc  <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_line_pos   <= n_line_pos;
            r_line_bad   <= n_line_bad;
            r_held_char  <= n_held_char;
            r_held_valid <= n_held_valid;
            r_group_pos  <= n_group_pos;
            r_group_acc  <= n_group_acc;
        end
    end

endmodule

// ===== rtl/scan_reply_decoder.sv =====
// scan_reply_decoder: top level of the range scan reply decoder.
// Depends on srd_pkg, srd_echo and srd_parse.
`timescale 1ns / 1ps

// Channel  | Direction | Payload
// ---------+-----------+---------------------------------------------------
// s_axis   | in        | tdata[7:0] rx_byte
// m_axis   | out       | tdata[17:0] range_value (zero padded to 24),
//          |           | tuser[1:0] kind
// cfg      | in        | i_cfg_we / i_cfg_index / i_cfg_data, write only
//
// One byte per cycle sustained while m_axis accepts. A transaction is held
// in the input register, is decoded in one pass against the parser state,
// and lands in the result register. A byte that gives no result frees its
// slot at once; a stalled m_axis holds the result register, and the input
// register then fills and s_axis_tready drops. Synchronous active-low reset
// clears the parser to waiting for an echo line and the settings to start
// 0, end 768, skip 1.

module scan_reply_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [srd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // received bytes
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] rx_byte
    // decoded results
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,   // [17:0] range_value
    output logic [1:0]                      m_axis_tuser    // [1:0] kind
);
    import srd_pkg::*;

    // Input register
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    // Result register
    logic                r_out_valid;
    logic [RANGE_W-1:0]  r_out_value;
    logic [KIND_W-1:0]   r_out_kind;

    logic                w_advance;
    logic                w_step;
    logic [POS_W-1:0]    w_line_pos;
    t_echo_ref           w_echo;
    t_result             w_result;

    // result register free or emptying this cycle
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    srd_echo u_echo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_line_pos  (w_line_pos),
        .o_echo      (w_echo)
    );

    srd_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_byte     (r_in_byte),
        .i_echo     (w_echo),
        .o_line_pos (w_line_pos),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_result.valid) begin
            r_out_value <= w_result.value;
            r_out_kind  <= w_result.kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_value};
    assign m_axis_tuser  = r_out_kind;

endmodule

// ===== bench/scan_reply_decoder_tb.sv =====
// scan_reply_decoder_tb: self-checking bench for the scan reply decoder.
// Needs srd_pkg and scan_reply_decoder; a scoreboard class predicts each result.
`timescale 1ns / 1ps

// Tracks the decoder state byte by byte and keeps the results still owed.
class scan_reply_checker;
    srd_pkg::t_phase   line_state;
    logic [6:0]        col_count;
    logic              line_err;
    logic [7:0]        pend_char;
    logic              pend_ok;
    logic [1:0]        grp_cnt;
    logic [11:0]       grp_bits;
    logic [9:0]        req_first;
    logic [9:0]        req_last;
    logic [6:0]        req_skip;
    logic [7:0]        line_ref [16];
    int unsigned       line_len;
    srd_pkg::t_result  results_due [$];
    int unsigned       errors;

    function new();
        req_first  = 10'd0;
        req_last   = 10'd768;
        req_skip   = 7'd1;
        line_state = srd_pkg::PH_ECHO;
        col_count  = '0;
        line_err   = 1'b0;
        errors     = 0;
        clear_data();
    endfunction

    function void clear_data();
        pend_char = '0;
        pend_ok   = 1'b0;
        grp_cnt   = '0;
        grp_bits  = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [9:0] value);
        case (idx)
            srd_pkg::CFG_START_STEP: req_first = value;
            srd_pkg::CFG_END_STEP:   req_last  = value;
            srd_pkg::CFG_SKIP_COUNT: req_skip  = value[6:0];
            default: ;
        endcase
    endfunction

    // ASCII digit of v at decimal place 'place' (0 = ones)
    function logic [7:0] dec_char(int unsigned v, int unsigned place);
        repeat (place) v = v / 10;
        return 8'h30 + 8'(v % 10);
    endfunction

    function int unsigned pending();
        return results_due.size();
    endfunction

    // Advance the prediction by one accepted byte
    function void note_byte(logic [7:0] c);
        logic [5:0]       six;
        logic             good;
        int unsigned      i;
        srd_pkg::t_result due;
        due       = '0;
        due.valid = 1'b1;
        case (line_state)
            srd_pkg::PH_ECHO, srd_pkg::PH_STATUS: begin
                if (line_state == srd_pkg::PH_ECHO) begin
                    line_ref[0] = "G";
                    line_ref[1] = "D";
                    for (i = 0; i < 4; i++) begin
                        line_ref[2 + i] = dec_char(req_first, 3 - i);
                        line_ref[6 + i] = dec_char(req_last, 3 - i);
                    end
                    // skip prints with three digits once it reaches 100
                    line_len = (req_skip >= 7'd100) ? 13 : 12;
                    for (i = 0; i < line_len - 10; i++)
                        line_ref[10 + i] = dec_char(req_skip, line_len - 11 - i);
                end else begin
                    line_ref[0] = "0";
                    line_ref[1] = "0";
                    line_ref[2] = "P";
                    line_len    = 3;
                end
                if (c == srd_pkg::C_NEWLINE) begin
                    good      = !line_err && (col_count == line_len);
                    col_count = '0;
                    line_err  = 1'b0;
                    if (good) begin
                        if (line_state == srd_pkg::PH_ECHO) line_state = srd_pkg::PH_STATUS;
                        else line_state = srd_pkg::PH_STAMP;
                    end else begin
                        if (line_state == srd_pkg::PH_ECHO) due.kind = srd_pkg::KIND_ECHO_BAD;
                        else due.kind = srd_pkg::KIND_STATUS_BAD;
                        results_due.push_back(due);
                        line_state = srd_pkg::PH_ECHO;
                    end
                end else begin
                    if (col_count >= line_len || line_ref[col_count] != c) line_err = 1'b1;
                    if (col_count != srd_pkg::C_POS_MAX) col_count++;
                end
            end
            srd_pkg::PH_STAMP: begin
                if (c == srd_pkg::C_NEWLINE) begin
                    line_state = srd_pkg::PH_DATA;
                    col_count  = '0;
                    line_err   = 1'b0;
                    clear_data();
                end
            end
            default: begin
                if (c == srd_pkg::C_NEWLINE) begin
                    if (col_count == 0) begin
                        // empty line: scan over, partial group dropped
                        clear_data();
                        line_state = srd_pkg::PH_ECHO;
                        line_err   = 1'b0;
                        due.kind   = srd_pkg::KIND_DONE;
                        results_due.push_back(due);
                    end else begin
                        // held byte was the checksum
                        pend_ok   = 1'b0;
                        pend_char = '0;
                        col_count = '0;
                    end
                end else begin
                    if (col_count != srd_pkg::C_POS_MAX) col_count++;
                    if (pend_ok) begin
                        six       = pend_char[5:0] - srd_pkg::C_CHAR_BIAS;
                        pend_char = c;
                        if (grp_cnt >= 2) begin
                            due.kind  = srd_pkg::KIND_RANGE;
                            due.value = {grp_bits, six};
                            results_due.push_back(due);
                            grp_cnt  = '0;
                            grp_bits = '0;
                        end else begin
                            grp_bits = {grp_bits[5:0], six};
                            grp_cnt++;
                        end
                    end else begin
                        pend_char = c;
                        pend_ok   = 1'b1;
                    end
                end
            end
        endcase
    endfunction

    task report(string msg);
        errors++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Compare one accepted result with the oldest one owed
    task check_result(logic [23:0] data, logic [1:0] kind);
        srd_pkg::t_result due;
        if (results_due.size() == 0) begin
            report($sformatf("result kind %0d data 0x%06h with nothing owed", kind, data));
        end else begin
            due = results_due.pop_front();
            if (kind != due.kind)
                report($sformatf("kind %0d, expected %0d", kind, due.kind));
            if (data != {6'd0, due.value})
                report($sformatf("data 0x%06h, expected 0x%06h", data, {6'd0, due.value}));
        end
    endtask
endclass

module scan_reply_decoder_tb;
    import srd_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1050;
    localparam int unsigned NUM_SETTINGS = 6;
    localparam int unsigned SETTLE       = 8;       // margin for the pipe to empty
    localparam int unsigned CYCLE_LIMIT  = 400000;  // watchdog limit, in clock cycles

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // [17:0] range_value, rest zero
    logic [1:0]  m_axis_tuser;    // [1:0] kind

    scan_reply_checker chk;

    // Stimulus-side copy of the settings, used to build matching echo lines
    int unsigned req_first;
    int unsigned req_last;
    int unsigned req_skip;
    int unsigned bytes_sent;
    int unsigned cycle_count;
    int unsigned hold_cycles;
    int unsigned rand_base;
    logic        idling;          // off gives back-to-back stretches on both sides

    scan_reply_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Both monitors sample at the rising edge; inputs move only at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            chk.note_byte(s_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            chk.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Result sink: random hold-off before each transaction while idling is set
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold_cycles = idling ? $urandom_range(0, 8) : 0;
            if (hold_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("scan_reply_decoder_tb: FAIL");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    // tvalid stays high straight into the next byte when no gap is drawn.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = idling ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        int unsigned i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Stop sending, wait until every owed result is in, then let the pipe empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (chk.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // All three registers back to back; only legal while the decoder is idle
    task automatic write_settings(input int unsigned first_step, input int unsigned last_step,
                                  input int unsigned skip);
        req_first = first_step;
        req_last  = last_step;
        req_skip  = skip;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_STEP;
        i_cfg_data  <= 10'(first_step);
        @(negedge i_clk);
        i_cfg_index <= CFG_END_STEP;
        i_cfg_data  <= 10'(last_step);
        @(negedge i_clk);
        i_cfg_index <= CFG_SKIP_COUNT;
        i_cfg_data  <= 10'(skip);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        chk.set_reg(CFG_START_STEP, 10'(first_step));
        chk.set_reg(CFG_END_STEP, 10'(last_step));
        chk.set_reg(CFG_SKIP_COUNT, 10'(skip));
    endtask

    function automatic logic [7:0] any_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == C_NEWLINE);
        return b;
    endfunction

    // Mostly the legal 0x30..0x6F alphabet, sometimes out of range
    function automatic logic [7:0] data_char();
        return ($urandom_range(0, 7) == 0) ? any_char() : 8'($urandom_range(48, 111));
    endfunction

    // Corrupt a line: flip one byte, drop one or insert one
    function automatic void mangle(ref logic [7:0] txt [$]);
        int unsigned at;
        at = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
            0:       txt[at] = txt[at] ^ 8'($urandom_range(1, 255));
            1:       txt.delete(at);
            default: txt.insert(at, 8'($urandom_range(32, 126)));
        endcase
    endfunction

    // One reply: mostly well formed with random payload, the rest line noise,
    // a broken echo, a broken status, or a scan without its closing empty line.
    task automatic send_reply();
        logic [7:0]  reply [$];
        logic [7:0]  status_q [$];
        string       echo_txt;
        int unsigned pick;
        int unsigned lines;
        int unsigned width;
        int unsigned k;
        echo_txt = $sformatf("GD%04d%04d%02d", req_first, req_last, req_skip);
        pick     = $urandom_range(0, 99);
        idling   = ($urandom_range(0, 3) != 0);
        if (pick < 8) begin
            // noise; a couple of lines are long enough to saturate the column count
            width = (pick < 2) ? $urandom_range(130, 150) : $urandom_range(1, 24);
            repeat (width) reply.push_back(pick < 2 ? any_char() : 8'($urandom_range(0, 255)));
            reply.push_back(C_NEWLINE);
        end else begin
            for (k = 0; k < echo_txt.len(); k++) reply.push_back(echo_txt[k]);
            if (pick < 20) begin
                mangle(reply);
                reply.push_back(C_NEWLINE);
            end else begin
                reply.push_back(C_NEWLINE);
                status_q = '{"0", "0", "P"};
                if (pick < 28) mangle(status_q);
                for (k = 0; k < status_q.size(); k++) reply.push_back(status_q[k]);
                reply.push_back(C_NEWLINE);
                if (pick >= 28) begin
                    // timestamp line, content ignored
                    repeat ($urandom_range(0, 6)) reply.push_back(8'($urandom_range(33, 126)));
                    reply.push_back(C_NEWLINE);
                    lines = $urandom_range(0, 5);
                    if (pick < 33 && lines == 0) lines = 1;
                    for (k = 0; k < lines; k++) begin
                        if (pick < 33 && k == 0) width = $urandom_range(130, 160);
                        else if ($urandom_range(0, 5) == 0) width = 0;  // checksum only
                        else width = $urandom_range(1, 24);
                        repeat (width) reply.push_back(data_char());
                        reply.push_back(8'($urandom_range(48, 111)));  // checksum
                        reply.push_back(C_NEWLINE);
                    end
                    // a few scans run on into the next reply without the end mark
                    if (pick >= 37) reply.push_back(C_NEWLINE);
                end
            end
        end
        for (k = 0; k < reply.size(); k++) send_byte(reply[k]);
    endtask

    initial begin
        int unsigned ph;
        chk           = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_START_STEP;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idling        = 1'b0;
        bytes_sent    = 0;
        req_first     = 0;
        req_last      = 768;
        req_skip      = 1;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: garbage echo with extreme bytes, then one full reply under the
        // reset settings with a single group that has an out-of-range character.
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(C_NEWLINE);
        send_text("GD0000076801\n00P\n\n0o");
        send_byte(8'hFF);
        send_text("?\n\n");
        wait_idle();

        // Random replies under several settings, extremes first
        rand_base = bytes_sent;
        for (ph = 0; ph < NUM_SETTINGS; ph++) begin
            case (ph)
                0: write_settings(0, 0, 0);
                1: write_settings(1023, 1023, 127);
                2: write_settings(768, 768, 99);
                3: write_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                                  $urandom_range(100, 127));
                4: write_settings($urandom_range(0, 768), $urandom_range(0, 768),
                                  $urandom_range(0, 99));
                default: write_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                                        $urandom_range(0, 127));
            endcase
            while (bytes_sent - rand_base < (ph + 1) * RANDOM_BYTES / NUM_SETTINGS)
                send_reply();
            wait_idle();
        end

        if (chk.errors == 0)
            $display("scan_reply_decoder_tb: PASS");
        else
            $display("scan_reply_decoder_tb: FAIL");
        $finish;
    end

endmodule
